FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the coordinate stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/csws_pkg.sv
// Types and constants shared by the coordinate stack modules.
`default_nettype none
package csws_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int QUEUE_DEPTH     = 2;

   // Request codes as they arrive on the input channel.
   localparam logic [2:0] REQ_PUSH     = 3'd0;
   localparam logic [2:0] REQ_POP      = 3'd1;
   localparam logic [2:0] REQ_PEEK     = 3'd2;
   localparam logic [2:0] REQ_CONTAINS = 3'd3;
   localparam logic [2:0] REQ_DELETE   = 3'd4;
   localparam logic [2:0] REQ_CLEAR    = 3'd5;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   // Classified operation carried from the front end to the engine.
   typedef enum logic [2:0] {
      OP_PUSH,
      OP_POP,
      OP_PEEK,
      OP_CONTAINS,
      OP_DELETE,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] key;
   } cmd_type;

   // Engine sequencer states.
   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_TOP,
      STATE_SCAN_RD,
      STATE_SCAN_CMP,
      STATE_SHIFT_RD,
      STATE_SHIFT_WR,
      STATE_RESP
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/coordinate_stack_with_search.sv
// Accepted requests are registered in the command queue before the engine takes them. Per
// request, push, clear and no-op go straight to the response state, pop and peek read the
// top entry first, contains scans down from the top and delete also shifts the entries above.
// The engine handles one request at a time; the two-entry queue takes requests meanwhile.
// Reset is synchronous and active high; it empties the stack and the queue at once.
// Top level of the coordinate stack with search.
`default_nettype none
`include "assert_macros.svh"
module coordinate_stack_with_search #(
   parameter int STACK_DEPTH = csws_pkg::STACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [15:0] req_coord_x,
   input  wire logic [15:0] req_coord_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_top_x,
   output logic [15:0]      rsp_top_y,
   output logic             rsp_found,
   output logic             rsp_is_empty,
   output logic [1:0]       rsp_status
);

   logic              q_full;
   logic              q_push;
   csws_pkg::cmd_type push_cmd;
   logic              q_valid;
   logic              q_pop;
   csws_pkg::cmd_type q_cmd;
   logic              rsp_underflow;

   // Front end classifies incoming transactions.
   csws_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   // Command queue decouples the two sides.
   csws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .q_valid  (q_valid),
      .pop      (q_pop),
      .q_cmd    (q_cmd)
   );

   // Engine executes commands against the stack memory.
   csws_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_top_x    (rsp_top_x),
      .rsp_top_y    (rsp_top_y),
      .rsp_found    (rsp_found),
      .rsp_is_empty (rsp_is_empty),
      .rsp_status   (rsp_status)
   );

   // A presented response that reports an underflow.
   assign rsp_underflow = rsp_valid && (rsp_status == csws_pkg::STATUS_UNDERFLOW);

   // The engine never takes a command from an empty queue.
   `ASSERT_IMPLIES(a_pop_needs_cmd, clock, reset, q_pop, q_valid)
   // An underflow can only be reported while the stack is empty.
   `ASSERT_IMPLIES(a_underflow_empty, clock, reset, rsp_underflow, rsp_is_empty)
   // A successful search never carries an error status.
   `ASSERT_IMPLIES(a_found_ok, clock, reset, rsp_valid && rsp_found, rsp_status == csws_pkg::STATUS_OK)

endmodule
`default_nettype wire

FILE: rtl/csws_front.sv
// Front end: accepts request transactions and classifies them into commands.
`default_nettype none
module csws_front (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_type,
   input  wire logic [15:0]       req_coord_x,
   input  wire logic [15:0]       req_coord_y,
   input  wire logic              q_full,
   output logic                   q_push,
   output csws_pkg::cmd_type      q_cmd
);

   csws_pkg::op_type op;

   // Map the request code onto an operation; unused codes become no-ops.
   always_comb begin
      unique case (req_type)
         csws_pkg::REQ_PUSH:     op = csws_pkg::OP_PUSH;
         csws_pkg::REQ_POP:      op = csws_pkg::OP_POP;
         csws_pkg::REQ_PEEK:     op = csws_pkg::OP_PEEK;
         csws_pkg::REQ_CONTAINS: op = csws_pkg::OP_CONTAINS;
         csws_pkg::REQ_DELETE:   op = csws_pkg::OP_DELETE;
         csws_pkg::REQ_CLEAR:    op = csws_pkg::OP_CLEAR;
         default:                op = csws_pkg::OP_NONE;
      endcase
   end

   // A transaction is taken whenever the command queue has room.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_cmd.op  = op;
   assign q_cmd.key = {req_coord_x, req_coord_y};

endmodule
`default_nettype wire

FILE: rtl/csws_queue.sv
// Short command queue between the front end and the stack engine.
`default_nettype none
module csws_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire csws_pkg::cmd_type push_cmd,
   output logic                   full,
   output logic                   q_valid,
   input  wire logic              pop,
   output csws_pkg::cmd_type      q_cmd
);

   localparam int DEPTH = csws_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW    = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

   csws_pkg::cmd_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;

   assign full    = (fill_ff == FULL_FILL);
   assign q_valid = (fill_ff != '0);
   assign q_cmd   = entries_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/csws_back.sv
// Stack engine: entry memory, sequencer for search and delete, result register.
`default_nettype none
module csws_back #(
   parameter int STACK_DEPTH = csws_pkg::STACK_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire csws_pkg::cmd_type q_cmd,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [15:0]            rsp_top_x,
   output logic [15:0]            rsp_top_y,
   output logic                   rsp_found,
   output logic                   rsp_is_empty,
   output logic [1:0]             rsp_status
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] ONE        = CW'(1);

   csws_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   csws_pkg::op_type    op_ff, op_in;
   logic [31:0]         key_ff, key_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [31:0]         res_top_ff, res_top_in;
   logic                res_found_ff, res_found_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic [31:0]         rsp_top_ff, rsp_top_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic [31:0]         mem [STACK_DEPTH];
   logic [31:0]         rdata_ff;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [31:0]         wr_data;

   logic [CW-1:0]       count_m1;
   logic [CW-1:0]       idx_ext;
   logic [CW-1:0]       idx_next_ext;
   logic                is_full;
   logic                is_empty;
   logic                key_match;
   logic                match_on_top;
   logic                shift_done;
   logic                out_free;

   // Shared status terms.
   assign count_m1     = count_ff - ONE;
   assign idx_ext      = CW'(idx_ff);
   assign idx_next_ext = idx_ext + ONE;
   assign is_full      = (count_ff == FULL_COUNT);
   assign is_empty     = (count_ff == '0);
   assign key_match    = (rdata_ff == key_ff);
   assign match_on_top = (idx_ext == count_m1);
   assign shift_done   = ((idx_next_ext + ONE) == count_ff);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csws_pkg::STATE_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op) inside
                  csws_pkg::OP_POP, csws_pkg::OP_PEEK:
                     state_in = is_empty ? csws_pkg::STATE_RESP : csws_pkg::STATE_TOP;
                  csws_pkg::OP_CONTAINS, csws_pkg::OP_DELETE:
                     state_in = is_empty ? csws_pkg::STATE_RESP : csws_pkg::STATE_SCAN_RD;
                  default:
                     state_in = csws_pkg::STATE_RESP;
               endcase
            end
         end
         csws_pkg::STATE_TOP:     state_in = csws_pkg::STATE_RESP;
         csws_pkg::STATE_SCAN_RD: state_in = csws_pkg::STATE_SCAN_CMP;
         csws_pkg::STATE_SCAN_CMP: begin
            if (key_match) begin
               state_in = (op_ff == csws_pkg::OP_DELETE && !match_on_top)
                        ? csws_pkg::STATE_SHIFT_RD : csws_pkg::STATE_RESP;
            end else begin
               state_in = (idx_ff == '0) ? csws_pkg::STATE_RESP : csws_pkg::STATE_SCAN_RD;
            end
         end
         csws_pkg::STATE_SHIFT_RD: state_in = csws_pkg::STATE_SHIFT_WR;
         csws_pkg::STATE_SHIFT_WR: begin
            state_in = shift_done ? csws_pkg::STATE_RESP : csws_pkg::STATE_SHIFT_RD;
         end
         csws_pkg::STATE_RESP: begin
            if (out_free) begin
               state_in = csws_pkg::STATE_IDLE;
            end
         end
         default: state_in = csws_pkg::STATE_IDLE;
      endcase
   end

   // Datapath, memory port and result register control per state.
   always_comb begin
      q_pop         = 1'b0;
      count_in      = count_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      res_top_in    = res_top_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rdata_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_top_in    = rsp_top_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         csws_pkg::STATE_IDLE: begin
            rd_addr = count_m1[AW-1:0];
            if (q_valid) begin
               q_pop         = 1'b1;
               op_in         = q_cmd.op;
               key_in        = q_cmd.key;
               idx_in        = count_m1[AW-1:0];
               res_top_in    = '0;
               res_found_in  = 1'b0;
               res_status_in = csws_pkg::STATUS_OK;
               case (q_cmd.op) inside
                  csws_pkg::OP_PUSH: begin
                     if (is_full) begin
                        res_status_in = csws_pkg::STATUS_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = q_cmd.key;
                        count_in = count_ff + ONE;
                     end
                  end
                  csws_pkg::OP_POP, csws_pkg::OP_PEEK: begin
                     if (is_empty) begin
                        res_status_in = csws_pkg::STATUS_UNDERFLOW;
                     end
                  end
                  csws_pkg::OP_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         csws_pkg::STATE_TOP: begin
            res_top_in = rdata_ff;
            if (op_ff == csws_pkg::OP_POP) begin
               count_in = count_m1;
            end
         end
         csws_pkg::STATE_SCAN_RD: ;
         csws_pkg::STATE_SCAN_CMP: begin
            if (key_match) begin
               res_found_in = 1'b1;
               if (op_ff == csws_pkg::OP_DELETE && match_on_top) begin
                  count_in = count_m1;
               end
            end else if (idx_ff != '0) begin
               idx_in = idx_ff - AW'(1);
            end
         end
         csws_pkg::STATE_SHIFT_RD: begin
            rd_addr = idx_next_ext[AW-1:0];
         end
         csws_pkg::STATE_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rdata_ff;
            idx_in  = idx_next_ext[AW-1:0];
            if (shift_done) begin
               count_in = count_m1;
            end
         end
         csws_pkg::STATE_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_top_in    = res_top_ff;
               rsp_found_in  = res_found_ff;
               rsp_empty_in  = is_empty;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csws_pkg::STATE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      res_top_ff    <= res_top_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Entry memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_top_x    = rsp_top_ff[31:16];
   assign rsp_top_y    = rsp_top_ff[15:0];
   assign rsp_found    = rsp_found_ff;
   assign rsp_is_empty = rsp_empty_ff;
   assign rsp_status   = rsp_status_ff;

endmodule
`default_nettype wire

FILE: verif/coordinate_stack_with_search_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the coordinate stack with search, with a predicting scoreboard.
module coordinate_stack_with_search_test;

   localparam int DEPTH = csws_pkg::STACK_DEPTH_DEF;
   // Request codes the block ignores.
   localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
   localparam logic [2:0] REQ_UNUSED_7 = 3'd7;
   localparam int RANDOM_ITEMS   = 800;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_GAP        = 60;
   localparam int DRAIN_LIMIT    = 40000;
   localparam int SETTLE_CYCLES  = 300;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [15:0] top_x;
      logic [15:0] top_y;
      logic        found;
      logic        is_empty;
      logic [1:0]  status;
   } stack_result_type;

   // Shadow stack that predicts each response and checks the ones that come back.
   class stack_scoreboard;
      logic [31:0]      slots [DEPTH];
      int unsigned      held;
      stack_result_type awaiting [$];
      int unsigned      mismatches;

      function new();
         held = 0;
         mismatches = 0;
      endfunction

      function void note_mismatch(string what, stack_result_type got, stack_result_type want);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t %s: expected x=%h y=%h found=%b empty=%b status=%0d", $time, what,
                     want.top_x, want.top_y, want.found, want.is_empty, want.status);
            $display("%0t %s: actual   x=%h y=%h found=%b empty=%b status=%0d", $time, what,
                     got.top_x, got.top_y, got.found, got.is_empty, got.status);
         end
      endfunction

      // Applies one accepted request to the shadow stack and queues the response it causes.
      function void note_request(logic [2:0] kind, logic [15:0] x, logic [15:0] y);
         stack_result_type want;
         logic [31:0]      key;
         int               hit;
         key = {x, y};
         want = '0;
         hit = -1;
         case (kind) inside
            csws_pkg::REQ_PUSH: begin
               if (held >= DEPTH) begin
                  want.status = csws_pkg::STATUS_OVERFLOW;
               end else begin
                  slots[held] = key;
                  held++;
               end
            end
            csws_pkg::REQ_POP, csws_pkg::REQ_PEEK: begin
               if (held == 0) begin
                  want.status = csws_pkg::STATUS_UNDERFLOW;
               end else begin
                  {want.top_x, want.top_y} = slots[held - 1];
                  if (kind == csws_pkg::REQ_POP) held--;
               end
            end
            csws_pkg::REQ_CONTAINS, csws_pkg::REQ_DELETE: begin
               // The topmost match wins; entries above it close the gap on a delete.
               for (int i = int'(held) - 1; i >= 0 && hit < 0; i--)
                  if (slots[i] == key) hit = i;
               want.found = (hit >= 0);
               if (kind == csws_pkg::REQ_DELETE && hit >= 0) begin
                  for (int i = hit; i + 1 < int'(held); i++) slots[i] = slots[i + 1];
                  held--;
               end
            end
            csws_pkg::REQ_CLEAR: begin
               held = 0;
            end
            default: begin
            end
         endcase
         want.is_empty = (held == 0);
         awaiting.push_back(want);
      endfunction

      // Compares one response with the oldest prediction.
      function void check_result(stack_result_type got);
         stack_result_type want;
         if (awaiting.size() == 0) begin
            note_mismatch("response with no request outstanding", got, '0);
         end else begin
            want = awaiting.pop_front();
            if (got.top_x !== want.top_x || got.top_y !== want.top_y ||
                got.found !== want.found || got.is_empty !== want.is_empty ||
                got.status !== want.status)
               note_mismatch("response mismatch", got, want);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_type;
   logic [15:0] req_coord_x;
   logic [15:0] req_coord_y;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_top_x;
   logic [15:0] rsp_top_y;
   logic        rsp_found;
   logic        rsp_is_empty;
   logic [1:0]  rsp_status;

   stack_scoreboard board;
   int unsigned     sender_idle_pct;
   int unsigned     receiver_stall_pct;
   bit              hold_off_request;

   coordinate_stack_with_search u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_top_x    (rsp_top_x),
      .rsp_top_y    (rsp_top_y),
      .rsp_found    (rsp_found),
      .rsp_is_empty (rsp_is_empty),
      .rsp_status   (rsp_status)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Offers one request, waits for its transaction, then idles at random.
   task automatic send_request(input logic [2:0] kind, input logic [15:0] x,
                               input logic [15:0] y);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (req_stall);
      board.note_request(kind, x, y);
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Mostly keys already on the stack, some one bit off, some extremes, the rest anything.
   function automatic logic [31:0] pick_key();
      logic [31:0] key;
      int unsigned r;
      int unsigned bit_pos;
      r = $urandom_range(99);
      if (board.held > 0 && r < 55) begin
         key = board.slots[$urandom_range(board.held - 1)];
      end else if (board.held > 0 && r < 70) begin
         key = board.slots[$urandom_range(board.held - 1)];
         bit_pos = $urandom_range(31);
         key[bit_pos] = ~key[bit_pos];
      end else if (r < 78) begin
         key = {($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000,
                ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000};
      end else begin
         key = $urandom;
      end
      return key;
   endfunction

   function automatic logic [2:0] random_kind();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 30) return csws_pkg::REQ_PUSH;
      if (r < 45) return csws_pkg::REQ_POP;
      if (r < 55) return csws_pkg::REQ_PEEK;
      if (r < 70) return csws_pkg::REQ_CONTAINS;
      if (r < 88) return csws_pkg::REQ_DELETE;
      if (r < 91) return csws_pkg::REQ_CLEAR;
      if (r < 96) return REQ_UNUSED_6;
      return REQ_UNUSED_7;
   endfunction

   // Receiver side: random stalls, or one long hold-off counted here.
   initial begin : receiver_side
      int unsigned hold_left;
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // Every accepted response goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_top_x, rsp_top_y, rsp_found, rsp_is_empty, rsp_status});
   end

   // Main sequence: reset, directed requests, random sequences, drain and verdict.
   initial begin : stimulus
      logic [31:0] key;
      logic [2:0]  kind;
      int unsigned sent;
      int unsigned seq;
      int unsigned wait_cycles;
      bit          first;
      board = new();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = csws_pkg::REQ_PUSH;
      req_coord_x = '0;
      req_coord_y = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Requests on an empty stack: underflow, no match, ignored code.
      send_request(csws_pkg::REQ_POP, 16'h0000, 16'h0000);
      send_request(csws_pkg::REQ_PEEK, 16'hFFFF, 16'hFFFF);
      send_request(csws_pkg::REQ_CONTAINS, 16'h0000, 16'h0000);
      send_request(csws_pkg::REQ_DELETE, 16'h0000, 16'h0000);
      send_request(REQ_UNUSED_6, 16'hFFFF, 16'hFFFF);
      // Extreme pairs, with a duplicate on top.
      send_request(csws_pkg::REQ_PUSH, 16'h0000, 16'h0000);
      send_request(csws_pkg::REQ_PUSH, 16'hFFFF, 16'hFFFF);
      send_request(csws_pkg::REQ_PUSH, 16'hFFFF, 16'h0000);
      send_request(csws_pkg::REQ_PUSH, 16'h0000, 16'hFFFF);
      send_request(csws_pkg::REQ_PUSH, 16'h0000, 16'h0000);
      send_request(csws_pkg::REQ_PEEK, 16'h1234, 16'h5678);
      send_request(csws_pkg::REQ_CONTAINS, 16'hFFFF, 16'h0000);
      send_request(csws_pkg::REQ_CONTAINS, 16'hFFFF, 16'hFFFE);
      // Delete the top duplicate, then a middle entry, then one that is not held.
      send_request(csws_pkg::REQ_DELETE, 16'h0000, 16'h0000);
      send_request(csws_pkg::REQ_DELETE, 16'hFFFF, 16'hFFFF);
      send_request(csws_pkg::REQ_DELETE, 16'h1234, 16'h5678);
      send_request(REQ_UNUSED_7, 16'hA5A5, 16'h5A5A);
      send_request(csws_pkg::REQ_POP, 16'h0000, 16'h0000);
      send_request(csws_pkg::REQ_PEEK, 16'h0000, 16'h0000);
      // Clear with entries held, pop after it, clear when already empty.
      send_request(csws_pkg::REQ_CLEAR, 16'h0000, 16'h0000);
      send_request(csws_pkg::REQ_POP, 16'h0000, 16'h0000);
      send_request(csws_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF);
      send_request(csws_pkg::REQ_PUSH, 16'h8001, 16'h7FFE);
      send_request(csws_pkg::REQ_POP, 16'h0000, 16'h0000);

      sent = 0;
      first = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         case ((sent * 4) / RANDOM_ITEMS)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 87;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 87;
            end
            default: begin
               sender_idle_pct = 25;
               receiver_stall_pct = 25;
            end
         endcase
         // The first sequence fills the stack while the receiver holds off.
         if (first) begin
            hold_off_request = 1'b1;
            seq = 0;
         end else begin
            seq = $urandom_range(19);
         end
         first = 1'b0;

         if (seq < 3) begin
            // Fill to the top, push past it, then search and delete deep entries.
            while (board.held < DEPTH) begin
               key = pick_key();
               send_request(csws_pkg::REQ_PUSH, key[31:16], key[15:0]);
               sent++;
            end
            repeat ($urandom_range(1, 3)) begin
               key = pick_key();
               send_request(csws_pkg::REQ_PUSH, key[31:16], key[15:0]);
               sent++;
            end
            repeat ($urandom_range(2, 6)) begin
               key = pick_key();
               kind = ($urandom_range(1) != 0) ? csws_pkg::REQ_DELETE : csws_pkg::REQ_CONTAINS;
               send_request(kind, key[31:16], key[15:0]);
               sent++;
            end
         end else if (seq < 5) begin
            // Drain to empty, then read past the bottom.
            while (board.held > 0) begin
               key = $urandom;
               send_request(csws_pkg::REQ_POP, key[31:16], key[15:0]);
               sent++;
            end
            repeat ($urandom_range(1, 2)) begin
               key = $urandom;
               kind = ($urandom_range(1) != 0) ? csws_pkg::REQ_POP : csws_pkg::REQ_PEEK;
               send_request(kind, key[31:16], key[15:0]);
               sent++;
            end
         end else begin
            // Mixed requests on keys that mostly hit the stack.
            repeat ($urandom_range(10, 40)) begin
               kind = random_kind();
               key = pick_key();
               send_request(kind, key[31:16], key[15:0]);
               if (kind != REQ_UNUSED_6 && kind != REQ_UNUSED_7) sent++;
            end
         end
      end
      req_valid <= 1'b0;

      // Wait for the outstanding responses, then let the block settle.
      wait_cycles = 0;
      while (board.awaiting.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (board.awaiting.size() != 0)
         board.note_mismatch("request never answered", '0, board.awaiting.pop_front());

      if (board.mismatches == 0) begin
         $display("[coordinate_stack_with_search] OK");
      end else begin
         $display("[coordinate_stack_with_search] ERROR");
      end
      $finish;
   end

   // Watchdog for a hung run.
   initial begin
      #(64'd30_000_000);
      $display("[coordinate_stack_with_search] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/csws_pkg.sv
rtl/csws_front.sv
rtl/csws_queue.sv
rtl/csws_back.sv
rtl/coordinate_stack_with_search.sv
verif/coordinate_stack_with_search_test.sv
